@@ rtl/mbrpeb_pkg.sv @@
`timescale 1ns / 1ps

package mbrpeb_pkg;

  // Field widths fixed by the entry format
  localparam int LBA_W    = 32;
  localparam int BYTE_W   = 8;
  localparam int CHS_W    = 24;
  localparam int CYL_W    = 10;
  localparam int SEC_W    = 7;
  localparam int IN_DW    = 2 * LBA_W;
  localparam int OUT_DW   = 2 * BYTE_W + 2 * CHS_W + 2 * LBA_W;

  // Lane depth: cylinder divider, spt reciprocal stage, CHS pack stage
  localparam int LANE_LAT = LBA_W + 2;

  // Geometry default: sectors per track
  localparam int SPT_DEFAULT = 63;

  // CHS clamp limits
  localparam logic [CYL_W-1:0]  CYL_MAX  = 10'd1023;
  localparam logic [BYTE_W-1:0] HEAD_MAX = 8'd254;
  localparam logic [SEC_W-1:0]  SEC_MAX  = 7'd63;
  localparam logic [SEC_W-1:0]  SEC_MIN  = 7'd1;

  // Configuration register map
  localparam int CFG_AW = 2;
  localparam logic [CFG_AW-1:0] REG_HEADS = 2'd0;
  localparam logic [CFG_AW-1:0] REG_BOOT  = 2'd1;
  localparam logic [CFG_AW-1:0] REG_TYPE  = 2'd2;

  // Register reset values
  localparam int                HEADS_RESET = 255;
  localparam logic [BYTE_W-1:0] BOOT_RESET  = 8'h00;
  localparam logic [BYTE_W-1:0] TYPE_RESET  = 8'h83;

endpackage

@@ rtl/mbrpeb_div_pipe.sv @@
`timescale 1ns / 1ps

// Pipelined restoring divider: one quotient bit per stage, DW stages.
module mbrpeb_div_pipe #(
  parameter int DW = 32,
  parameter int VW = 14
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic [DW-1:0] quotient,
  output logic [VW-1:0] remainder
);

  logic [VW-1:0] rem_r [DW];
  logic [DW-1:0] dq_r  [DW];   // remaining dividend bits shifted out, quotient bits shifted in

  for (genvar k = 0; k < DW; k++) begin : g_stage
    logic [VW-1:0] rem_prev;
    logic [DW-1:0] dq_prev;
    logic [VW:0]   trial;
    logic [VW:0]   diff;
    logic          ge;
    logic [VW-1:0] rem_nxt;
    logic [DW-1:0] dq_nxt;

    if (k == 0) begin : g_first
      assign rem_prev = '0;
      assign dq_prev  = dividend;
    end else begin : g_next
      assign rem_prev = rem_r[k-1];
      assign dq_prev  = dq_r[k-1];
    end

    assign trial   = {rem_prev, dq_prev[DW-1]};
    assign diff    = trial - {1'b0, divisor};
    assign ge      = (trial >= {1'b0, divisor});
    assign rem_nxt = ge ? diff[VW-1:0] : trial[VW-1:0];
    assign dq_nxt  = {dq_prev[DW-2:0], ge};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        dq_r[k]  <= dq_nxt;
      end
    end
  end

  assign quotient  = dq_r[DW-1];
  assign remainder = rem_r[DW-1];

endmodule

@@ rtl/mbrpeb_chs_lane.sv @@
`timescale 1ns / 1ps

// One LBA -> packed CHS lane; registers advance only while en is high.
module mbrpeb_chs_lane
  import mbrpeb_pkg::*;
#(
  parameter int SPT = SPT_DEFAULT
) (
  input  logic                                      clk,
  input  logic                                      en,
  input  logic [BYTE_W+$clog2(((SPT==0)?1:SPT)+1)-1:0] per_cyl,
  input  logic [LBA_W-1:0]                          lba,
  output logic [CHS_W-1:0]                          chs
);

  localparam int SPT_EFF = (SPT == 0) ? 1 : SPT;
  localparam int SPT_W   = $clog2(SPT_EFF + 1);
  localparam int PC_W    = BYTE_W + SPT_W;
  // reciprocal of spt; exact for every dividend below 2^PC_W
  localparam int REC_S   = PC_W + SPT_W;
  localparam int PROD_W  = PC_W + REC_S;
  localparam int REC_M   = ((1 << REC_S) + SPT_EFF - 1) / SPT_EFF;

  logic [LBA_W-1:0]  cyl_q;
  logic [PC_W-1:0]   rem_cyl;
  logic [PROD_W-1:0] head_prod;
  logic [PC_W-1:0]   head_nxt;
  logic [PC_W-1:0]   head_r;
  logic [PC_W-1:0]   rem_cyl_r;
  logic [CYL_W-1:0]  cyl_sat;
  logic [CYL_W-1:0]  cyl_r;
  logic [SPT_W-1:0]  rem_sec;
  logic [BYTE_W-1:0] head_sat;
  logic [SEC_W-1:0]  sec_raw;
  logic [SEC_W-1:0]  sec_sat;
  logic [BYTE_W-1:0] b1;
  logic [CHS_W-1:0]  chs_r;

  // lba / (heads * spt)
  mbrpeb_div_pipe #(.DW(LBA_W), .VW(PC_W)) u_div_cyl (
    .clk       (clk),
    .en        (en),
    .dividend  (lba),
    .divisor   (per_cyl),
    .quotient  (cyl_q),
    .remainder (rem_cyl)
  );

  // remainder / spt by reciprocal multiply
  assign head_prod = PROD_W'(rem_cyl) * PROD_W'(REC_M);
  assign head_nxt  = head_prod[PROD_W-1:REC_S];

  assign cyl_sat = (cyl_q > LBA_W'(CYL_MAX)) ? CYL_MAX : cyl_q[CYL_W-1:0];

  // sector index: only the low bits matter, the true value is below spt
  assign rem_sec = rem_cyl_r[SPT_W-1:0] - SPT_W'(head_r * SPT_EFF);

  always_comb begin
    head_sat = (head_r > PC_W'(HEAD_MAX)) ? HEAD_MAX : head_r[BYTE_W-1:0];
    sec_raw  = SEC_W'(rem_sec) + SEC_MIN;
    if (sec_raw > SEC_MAX) begin
      sec_sat = SEC_MAX;
    end else if (sec_raw < SEC_MIN) begin
      sec_sat = SEC_MIN;
    end else begin
      sec_sat = sec_raw;
    end
    b1 = {cyl_r[9:8], 6'd0} + BYTE_W'(sec_sat);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      head_r    <= head_nxt;
      rem_cyl_r <= rem_cyl;
      cyl_r     <= cyl_sat;
      chs_r     <= {cyl_r[7:0], b1, head_sat};
    end
  end

  assign chs = chs_r;

endmodule

@@ rtl/mbr_partition_entry_builder.sv @@
`timescale 1ns / 1ps

// Channel  Dir  Handshake          Payload
// in_      in   tvalid/tready      start_block, end_block
// out_     out  tvalid/tready      boot, start CHS, type, end CHS, first sector, count
// cfg_     in   wr_en (no wait)    heads / boot flag / type register write
//
// One request per cycle sustained while the output is accepted. The path is a 32-stage
// divider by heads*spt, a reciprocal multiply stage for the division by spt, a CHS pack
// stage and the output register.
// Reset (synchronous, rst_n low) empties the pipeline and loads the register
// defaults. A stalled output only holds the pipeline once its last stage is
// full; bubbles ahead of it keep collapsing and input is still taken.
module mbr_partition_entry_builder
  import mbrpeb_pkg::*;
#(
  parameter int SECTORS_PER_TRACK_GEOM = SPT_DEFAULT
) (
  input  logic              clk,
  input  logic              rst_n,
  // configuration
  input  logic              cfg_wr_en,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [BYTE_W-1:0] cfg_wdata,
  // input requests
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,   // [31:0] start_block, [63:32] end_block
  // results
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata   // [7:0] boot_byte, [31:8] first_chs,
                                        // [39:32] type_byte, [63:40] end_chs,
                                        // [95:64] first_sector, [127:96] sector_count
);

  localparam int SPT_EFF = (SECTORS_PER_TRACK_GEOM == 0) ? 1 : SECTORS_PER_TRACK_GEOM;
  localparam int SPT_W   = $clog2(SPT_EFF + 1);
  localparam int PC_W    = BYTE_W + SPT_W;
  localparam int LAT     = LANE_LAT;   // lane depth

  // config registers; heads kept as the precomputed cylinder size
  logic [PC_W-1:0]   per_cyl_r;
  logic [PC_W-1:0]   per_cyl_nxt;
  logic [BYTE_W-1:0] heads_eff;
  logic [BYTE_W-1:0] boot_r;
  logic [BYTE_W-1:0] type_r;

  // pipeline control and sideband
  logic [LAT-1:0]    v_r;
  logic [LBA_W-1:0]  first_r [LAT];
  logic [LBA_W-1:0]  cnt_r   [LAT];
  logic              shift;
  logic              load_out;

  logic [LBA_W-1:0]  start_blk;
  logic [LBA_W-1:0]  end_blk;
  logic [CHS_W-1:0]  first_chs;
  logic [CHS_W-1:0]  end_chs;

  logic              out_valid_r;
  logic [OUT_DW-1:0] out_data_r;

  assign start_blk = in_tdata[LBA_W-1:0];
  assign end_blk   = in_tdata[IN_DW-1:LBA_W];

  // zero heads counts as one
  assign heads_eff   = (cfg_wdata == '0) ? 8'd1 : cfg_wdata;
  assign per_cyl_nxt = PC_W'(heads_eff * SPT_EFF);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      per_cyl_r <= PC_W'(HEADS_RESET * SPT_EFF);
      boot_r    <= BOOT_RESET;
      type_r    <= TYPE_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_HEADS: per_cyl_r <= per_cyl_nxt;
        REG_BOOT:  boot_r    <= cfg_wdata;
        REG_TYPE:  type_r    <= cfg_wdata;
        default: ;   // unmapped index: ignored
      endcase
    end
  end

  // output slot free, or last stage empty: pipeline may move
  assign load_out  = !out_valid_r || out_tready;
  assign shift     = !v_r[LAT-1] || load_out;
  assign in_tready = shift;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (shift) begin
      v_r <= {v_r[LAT-2:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      first_r[0] <= start_blk;
      cnt_r[0]   <= end_blk - start_blk + 32'd1;   // wraps on reversed ranges
      for (int k = 1; k < LAT; k++) begin
        first_r[k] <= first_r[k-1];
        cnt_r[k]   <= cnt_r[k-1];
      end
    end
  end

  // two lanes: start and end address
  mbrpeb_chs_lane #(.SPT(SECTORS_PER_TRACK_GEOM)) u_lane_start (
    .clk     (clk),
    .en      (shift),
    .per_cyl (per_cyl_r),
    .lba     (start_blk),
    .chs     (first_chs)
  );

  mbrpeb_chs_lane #(.SPT(SECTORS_PER_TRACK_GEOM)) u_lane_end (
    .clk     (clk),
    .en      (shift),
    .per_cyl (per_cyl_r),
    .lba     (end_blk),
    .chs     (end_chs)
  );

  // merge: lane results plus sideband and config bytes into the entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= v_r[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (load_out && v_r[LAT-1]) begin
      out_data_r <= {cnt_r[LAT-1], first_r[LAT-1], end_chs, type_r, first_chs, boot_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
